/* design/assert_macros.svh */
// Assertion macros used by the checker module ccmxyz_chk.
// Both report through $error with a fixed message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define CCM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property that also holds through reset.
`define CCM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/ccmxyz_pkg.sv */
// ----------------------------------------------------------------------------
// ccmxyz_pkg
// Shared constants and types for the CCM to XYZ matrix block.
// ----------------------------------------------------------------------------
`default_nettype none

package ccmxyz_pkg;

    localparam int N_ELEM       = 9;    // 3x3 matrix, row major
    localparam int C_W          = 16;   // input coefficient width
    localparam int S_W          = 17;   // signed width of the sRGB->XYZ constants
    localparam int RES_W        = 32;   // output element width
    localparam int THR_W        = 16;   // determinant threshold width
    localparam int ADJ_FRAC     = 16;   // fraction bits of M and of the cofactors
    localparam int IN_FRAC_DEF  = 12;
    localparam int OUT_FRAC_DEF = 16;
    localparam int PRE_LAT      = 9;            // stages ahead of the divider
    localparam int DIV_LAT      = RES_W + 3;    // divider stages

    localparam logic [THR_W-1:0] THR_RESET = 16'd1;

    typedef logic signed [S_W-1:0] coef_t;
    typedef logic [3:0]            elem_idx_t;

    // sRGB to XYZ (D65), Q1.16, rounded to nearest
    localparam coef_t SRGB_XYZ [N_ELEM] = '{
        17'sd27031, 17'sd23434, 17'sd11825,
        17'sd13938, 17'sd46868, 17'sd4730,
        17'sd1267,  17'sd7811,  17'sd62279
    };

    // cofactor e = M[a]*M[b] - M[c]*M[d], as {a, b, c, d}
    localparam elem_idx_t COF_IDX [N_ELEM][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

endpackage

`default_nettype wire

/* design/ccmxyz_div.sv */
// ----------------------------------------------------------------------------
// ccmxyz_div
// Pipelined saturating divider, one quotient bit per stage, N_ELEM lanes
// sharing one divisor. res = sat(round(num * 2^SH / den)), sign applied.
// ----------------------------------------------------------------------------
`default_nettype none

module ccmxyz_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 60,
    parameter int SH    = 32
) (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire logic [NUM_W-1:0]                num_mag [ccmxyz_pkg::N_ELEM],
    input  wire logic [ccmxyz_pkg::N_ELEM-1:0]   neg,
    input  wire logic [DEN_W-1:0]                den,
    output logic      [ccmxyz_pkg::RES_W-1:0]    res [ccmxyz_pkg::N_ELEM]
);
    import ccmxyz_pkg::*;

    localparam int QW = RES_W;
    localparam int RW = NUM_W + SH;
    localparam int XW = RW + DEN_W;
    localparam logic [QW:0] LIM_POS = {2'b00, {(QW-1){1'b1}}};
    localparam logic [QW:0] LIM_NEG = {2'b01, {(QW-1){1'b0}}};

    logic [RW-1:0]     r_reg   [QW+1][N_ELEM];
    logic [QW-1:0]     q_reg   [QW+1][N_ELEM];
    logic [N_ELEM-1:0] sat_reg [QW+1];
    logic [N_ELEM-1:0] neg_reg [QW+1];
    logic [DEN_W-1:0]  d_reg   [QW+1];

    logic [QW:0]       qr_reg [N_ELEM];
    logic [N_ELEM-1:0] sat_r_reg;
    logic [N_ELEM-1:0] neg_r_reg;
    logic [QW-1:0]     res_reg [N_ELEM];

    // entry: quotient at or above 2^QW saturates outright
    always_ff @(posedge clk) begin
        if (en) begin
            for (int l = 0; l < N_ELEM; l++) begin
                r_reg[0][l]   <= RW'(num_mag[l]) << SH;
                q_reg[0][l]   <= '0;
                sat_reg[0][l] <= (XW'(num_mag[l]) << SH) >= (XW'(den) << QW);
            end
            neg_reg[0] <= neg;
            d_reg[0]   <= den;
        end
    end

    // restoring stages, bit k = QW - s
    for (genvar s = 1; s <= QW; s++) begin : g_bit
        localparam int K = QW - s;
        logic [RW-1:0] r_next [N_ELEM];
        logic [QW-1:0] q_next [N_ELEM];

        always_comb begin
            logic [XW-1:0] rx;
            logic [XW-1:0] dx;
            logic          ge;
            for (int l = 0; l < N_ELEM; l++) begin
                rx = XW'(r_reg[s-1][l]);
                dx = XW'(d_reg[s-1]) << K;
                ge = rx >= dx;
                r_next[l] = ge ? RW'(rx - dx) : r_reg[s-1][l];
                q_next[l] = q_reg[s-1][l] | (QW'(ge) << K);
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                r_reg[s]   <= r_next;
                q_reg[s]   <= q_next;
                sat_reg[s] <= sat_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                d_reg[s]   <= d_reg[s-1];
            end
        end
    end

    // round half up on the remainder, then limit check
    always_ff @(posedge clk) begin
        if (en) begin
            for (int l = 0; l < N_ELEM; l++) begin
                qr_reg[l] <= (QW+1)'(q_reg[QW][l])
                           + (QW+1)'((XW'(r_reg[QW][l]) << 1) >= XW'(d_reg[QW]));
            end
            sat_r_reg <= sat_reg[QW];
            neg_r_reg <= neg_reg[QW];
        end
    end

    // saturate and apply sign
    always_ff @(posedge clk) begin
        logic [QW:0] lim;
        logic [QW:0] negq;
        if (en) begin
            for (int l = 0; l < N_ELEM; l++) begin
                lim  = neg_r_reg[l] ? LIM_NEG : LIM_POS;
                negq = (QW+1)'(0) - qr_reg[l];
                if (sat_r_reg[l] || (qr_reg[l] > lim))
                    res_reg[l] <= lim[QW-1:0];
                else if (neg_r_reg[l])
                    res_reg[l] <= negq[QW-1:0];
                else
                    res_reg[l] <= qr_reg[l][QW-1:0];
            end
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

/* design/ccm_to_xyz_color_matrix.sv */
// ----------------------------------------------------------------------------
// ccm_to_xyz_color_matrix
// Camera CCM (Q3.12) times sRGB->XYZ, inverted by cofactors: XYZ->camera.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: nine signed Q3.12 CCM coefficients, valid/ready handshake.
//   Output beat: nine signed Q15.16 inverse entries (saturated) plus
//   inverted_ok; on a small or zero determinant the identity is returned
//   with inverted_ok low.
//   cfg_we/cfg_data write det_threshold (reset value 1); write only while idle.
//   Throughput: one beat per cycle while the output is not stalled. The
//   datapath is 9 + (RES_W + 3) = 44 pipeline stages plus the output
//   register; the divider's one-quotient-bit-per-stage array holds most of them.
//   Stall: a two-entry output buffer (output register + skid) sits after the
//   pipeline. When the receiver stalls, the beat leaving the pipeline parks
//   in the skid and the pipeline holds on the next cycle; in_ready is the
//   registered "skid empty" flag, so no combinational path runs from
//   out_ready to in_ready. Nothing is dropped or repeated across a stall.
//   Reset: async, active low; clears all valid bits, the buffer's included,
//   and restores det_threshold. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_to_xyz_color_matrix #(
    parameter int IN_FRAC_BITS  = ccmxyz_pkg::IN_FRAC_DEF,
    parameter int OUT_FRAC_BITS = ccmxyz_pkg::OUT_FRAC_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [ccmxyz_pkg::THR_W-1:0]        cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [ccmxyz_pkg::C_W-1:0]   ccm_r0c0,
    input  wire logic signed [ccmxyz_pkg::C_W-1:0]   ccm_r0c1,
    input  wire logic signed [ccmxyz_pkg::C_W-1:0]   ccm_r0c2,
    input  wire logic signed [ccmxyz_pkg::C_W-1:0]   ccm_r1c0,
    input  wire logic signed [ccmxyz_pkg::C_W-1:0]   ccm_r1c1,
    input  wire logic signed [ccmxyz_pkg::C_W-1:0]   ccm_r1c2,
    input  wire logic signed [ccmxyz_pkg::C_W-1:0]   ccm_r2c0,
    input  wire logic signed [ccmxyz_pkg::C_W-1:0]   ccm_r2c1,
    input  wire logic signed [ccmxyz_pkg::C_W-1:0]   ccm_r2c2,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [ccmxyz_pkg::RES_W-1:0]      xyz_r0c0,
    output logic signed [ccmxyz_pkg::RES_W-1:0]      xyz_r0c1,
    output logic signed [ccmxyz_pkg::RES_W-1:0]      xyz_r0c2,
    output logic signed [ccmxyz_pkg::RES_W-1:0]      xyz_r1c0,
    output logic signed [ccmxyz_pkg::RES_W-1:0]      xyz_r1c1,
    output logic signed [ccmxyz_pkg::RES_W-1:0]      xyz_r1c2,
    output logic signed [ccmxyz_pkg::RES_W-1:0]      xyz_r2c0,
    output logic signed [ccmxyz_pkg::RES_W-1:0]      xyz_r2c1,
    output logic signed [ccmxyz_pkg::RES_W-1:0]      xyz_r2c2,
    output logic                                     inverted_ok
);
    import ccmxyz_pkg::*;

    // datapath widths
    localparam int P1_W  = C_W + S_W;                  // CCM * constant
    localparam int ACC_W = P1_W + 2;                   // sum of three
    localparam int M_W   = ACC_W - IN_FRAC_BITS + 1;   // M, Q.16
    localparam int CP_W  = 2 * M_W;                    // cofactor product
    localparam int CD_W  = CP_W + 1;                   // cofactor difference
    localparam int ADJ_W = CD_W - ADJ_FRAC + 1;        // cofactor, Q.16
    localparam int DP_W  = M_W + ADJ_W;                // det product
    localparam int DET_W = DP_W + 2;                   // det, Q.32
    localparam int SH    = ADJ_FRAC + OUT_FRAC_BITS;
    localparam int NPIPE = PRE_LAT + DIV_LAT;

    localparam logic signed [ACC_W:0] M_HALF    = (ACC_W+1)'(1) <<< (IN_FRAC_BITS - 1);
    localparam logic signed [ACC_W:0] M_HALF_DN = M_HALF - (ACC_W+1)'(1);
    localparam logic signed [CD_W:0]  A_HALF    = (CD_W+1)'(1) <<< (ADJ_FRAC - 1);
    localparam logic signed [CD_W:0]  A_HALF_DN = A_HALF - (CD_W+1)'(1);
    localparam logic [RES_W-1:0]      ONE       = RES_W'(1) << OUT_FRAC_BITS;

    typedef struct packed {
        logic [N_ELEM-1:0][RES_W-1:0] mat;
        logic                         ok;
    } result_t;

    logic signed [C_W-1:0] c_in [N_ELEM];
    assign c_in = '{ccm_r0c0, ccm_r0c1, ccm_r0c2,
                    ccm_r1c0, ccm_r1c1, ccm_r1c2,
                    ccm_r2c0, ccm_r2c1, ccm_r2c2};

    // global advance: the whole pipeline moves unless the skid is occupied
    logic en;
    logic [NPIPE-1:0] v_reg;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    // det_threshold
    logic [THR_W-1:0] thr_reg;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_we)
            thr_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NPIPE-2:0], in_valid};
    end

    // stage 1: C * S products, p1[i*3+j][k] = C[i][k] * S[k][j]
    logic signed [P1_W-1:0] p1_reg [N_ELEM][3];
    always_ff @(posedge clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    for (int k = 0; k < 3; k++)
                        p1_reg[i*3+j][k] <= P1_W'(c_in[i*3+k]) * P1_W'(SRGB_XYZ[k*3+j]);
        end
    end

    // stage 2: row/column sums
    logic signed [ACC_W-1:0] acc_reg [N_ELEM];
    always_ff @(posedge clk) begin
        if (en) begin
            for (int e = 0; e < N_ELEM; e++)
                acc_reg[e] <= ACC_W'(p1_reg[e][0]) + ACC_W'(p1_reg[e][1])
                            + ACC_W'(p1_reg[e][2]);
        end
    end

    // stage 3: round to Q.16, half away from zero
    logic signed [M_W-1:0] m_reg [N_ELEM];
    always_ff @(posedge clk) begin
        logic signed [ACC_W:0] rnd;
        if (en) begin
            for (int e = 0; e < N_ELEM; e++) begin
                rnd = (ACC_W+1)'(acc_reg[e])
                    + (acc_reg[e][ACC_W-1] ? M_HALF_DN : M_HALF);
                m_reg[e] <= M_W'(rnd >>> IN_FRAC_BITS);
            end
        end
    end

    // stage 4: cofactor products; top row of M carried for the determinant
    logic signed [CP_W-1:0] cp_reg [N_ELEM][2];
    logic signed [M_W-1:0]  m4_reg [3];
    always_ff @(posedge clk) begin
        if (en) begin
            for (int e = 0; e < N_ELEM; e++) begin
                cp_reg[e][0] <= CP_W'(m_reg[COF_IDX[e][0]]) * CP_W'(m_reg[COF_IDX[e][1]]);
                cp_reg[e][1] <= CP_W'(m_reg[COF_IDX[e][2]]) * CP_W'(m_reg[COF_IDX[e][3]]);
            end
            for (int k = 0; k < 3; k++)
                m4_reg[k] <= m_reg[k];
        end
    end

    // stage 5: cofactor differences
    logic signed [CD_W-1:0] cd_reg [N_ELEM];
    logic signed [M_W-1:0]  m5_reg [3];
    always_ff @(posedge clk) begin
        if (en) begin
            for (int e = 0; e < N_ELEM; e++)
                cd_reg[e] <= CD_W'(cp_reg[e][0]) - CD_W'(cp_reg[e][1]);
            m5_reg <= m4_reg;
        end
    end

    // stage 6: cofactors rounded to Q.16
    logic signed [ADJ_W-1:0] adj_reg [N_ELEM];
    logic signed [M_W-1:0]   m6_reg  [3];
    always_ff @(posedge clk) begin
        logic signed [CD_W:0] rnd;
        if (en) begin
            for (int e = 0; e < N_ELEM; e++) begin
                rnd = (CD_W+1)'(cd_reg[e]) + (cd_reg[e][CD_W-1] ? A_HALF_DN : A_HALF);
                adj_reg[e] <= ADJ_W'(rnd >>> ADJ_FRAC);
            end
            m6_reg <= m5_reg;
        end
    end

    // stage 7: determinant terms, expansion along the first row
    logic signed [DP_W-1:0]  dp_reg   [3];
    logic signed [ADJ_W-1:0] adj7_reg [N_ELEM];
    always_ff @(posedge clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++)
                dp_reg[k] <= DP_W'(m6_reg[k]) * DP_W'(adj_reg[k*3]);
            adj7_reg <= adj_reg;
        end
    end

    // stage 8: determinant
    logic signed [DET_W-1:0] det_reg;
    logic signed [ADJ_W-1:0] adj8_reg [N_ELEM];
    always_ff @(posedge clk) begin
        if (en) begin
            det_reg  <= DET_W'(dp_reg[0]) + DET_W'(dp_reg[1]) + DET_W'(dp_reg[2]);
            adj8_reg <= adj7_reg;
        end
    end

    // stage 9: magnitudes, signs, invertibility test
    logic [ADJ_W-1:0]  num_reg [N_ELEM];
    logic [N_ELEM-1:0] qneg_reg;
    logic [DET_W-1:0]  den_reg;
    logic              fail9_reg;
    always_ff @(posedge clk) begin
        logic [DET_W-1:0] dmag;
        if (en) begin
            dmag = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
            for (int e = 0; e < N_ELEM; e++) begin
                num_reg[e]  <= adj8_reg[e][ADJ_W-1] ? ADJ_W'(-adj8_reg[e])
                                                    : ADJ_W'(adj8_reg[e]);
                qneg_reg[e] <= adj8_reg[e][ADJ_W-1] ^ det_reg[DET_W-1];
            end
            den_reg   <= dmag;
            fail9_reg <= (det_reg == '0) || (dmag < DET_W'(thr_reg));
        end
    end

    // divider array
    logic [RES_W-1:0] div_res [N_ELEM];
    ccmxyz_div #(
        .NUM_W (ADJ_W),
        .DEN_W (DET_W),
        .SH    (SH)
    ) u_div (
        .clk     (clk),
        .en      (en),
        .num_mag (num_reg),
        .neg     (qneg_reg),
        .den     (den_reg),
        .res     (div_res)
    );

    // fallback flag rides alongside the divider
    logic [DIV_LAT-1:0] fail_pipe_reg;
    always_ff @(posedge clk) begin
        if (en)
            fail_pipe_reg <= {fail_pipe_reg[DIV_LAT-2:0], fail9_reg};
    end

    // tail beat: identity replaces the quotient on fallback
    result_t tail_next;
    always_comb begin
        for (int e = 0; e < N_ELEM; e++) begin
            if (fail_pipe_reg[DIV_LAT-1])
                tail_next.mat[e] = (e % 4 == 0) ? ONE : '0;
            else
                tail_next.mat[e] = div_res[e];
        end
        tail_next.ok = !fail_pipe_reg[DIV_LAT-1];
    end

    // output register + skid
    logic    tail_valid;
    logic    load_out;
    result_t out_data_reg;
    result_t skid_data_reg;

    assign tail_valid = v_reg[NPIPE-1];
    assign load_out   = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_ready)
                skid_valid_reg <= 1'b0;
        end else if (tail_valid) begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (skid_valid_reg) begin
            if (out_ready)
                out_data_reg <= skid_data_reg;
        end else if (tail_valid) begin
            if (load_out)
                out_data_reg <= tail_next;
            else
                skid_data_reg <= tail_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign xyz_r0c0    = out_data_reg.mat[0];
    assign xyz_r0c1    = out_data_reg.mat[1];
    assign xyz_r0c2    = out_data_reg.mat[2];
    assign xyz_r1c0    = out_data_reg.mat[3];
    assign xyz_r1c1    = out_data_reg.mat[4];
    assign xyz_r1c2    = out_data_reg.mat[5];
    assign xyz_r2c0    = out_data_reg.mat[6];
    assign xyz_r2c1    = out_data_reg.mat[7];
    assign xyz_r2c2    = out_data_reg.mat[8];
    assign inverted_ok = out_data_reg.ok;

endmodule

`default_nettype wire

/* design/ccmxyz_chk.sv */
// ----------------------------------------------------------------------------
// ccmxyz_chk
// Port-level checks for ccm_to_xyz_color_matrix, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ccmxyz_chk #(
    parameter int OUT_FRAC_BITS = ccmxyz_pkg::OUT_FRAC_DEF
) (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_ready,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic signed [ccmxyz_pkg::RES_W-1:0] xyz_r0c0,
    input wire logic signed [ccmxyz_pkg::RES_W-1:0] xyz_r0c1,
    input wire logic signed [ccmxyz_pkg::RES_W-1:0] xyz_r0c2,
    input wire logic signed [ccmxyz_pkg::RES_W-1:0] xyz_r1c0,
    input wire logic signed [ccmxyz_pkg::RES_W-1:0] xyz_r1c1,
    input wire logic signed [ccmxyz_pkg::RES_W-1:0] xyz_r1c2,
    input wire logic signed [ccmxyz_pkg::RES_W-1:0] xyz_r2c0,
    input wire logic signed [ccmxyz_pkg::RES_W-1:0] xyz_r2c1,
    input wire logic signed [ccmxyz_pkg::RES_W-1:0] xyz_r2c2,
    input wire logic                                inverted_ok
);
    import ccmxyz_pkg::*;

    localparam logic [RES_W-1:0] ONE = RES_W'(1) << OUT_FRAC_BITS;

    // a held result beat keeps xyz_r0c0, xyz_r1c1 and inverted_ok
    `CCM_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(xyz_r0c0) && $stable(xyz_r1c1) && $stable(inverted_ok)), "output beat changed while stalled")

    // input only backs up after the output has stalled with a beat pending
    `CCM_ASSERT(a_in_stall, !in_ready |-> (out_valid && $past(out_valid && !out_ready)), "input stalled without an output stall")

    // fallback beats carry the identity
    `CCM_ASSERT(a_identity, (out_valid && !inverted_ok) |-> (xyz_r0c0 == ONE && xyz_r1c1 == ONE && xyz_r2c2 == ONE && xyz_r0c1 == 0 && xyz_r0c2 == 0 && xyz_r1c0 == 0 && xyz_r1c2 == 0 && xyz_r2c0 == 0 && xyz_r2c1 == 0), "fallback beat is not the identity")

    // nothing comes out right after reset
    `CCM_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "output valid right after reset")

endmodule

bind ccm_to_xyz_color_matrix ccmxyz_chk #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_ccmxyz_chk (.*);

`default_nettype wire
